/* sv/rxas_pkg.sv */
// ----------------------------------------------------------------------------
// rxas_pkg: shared types and constants of the RX anomaly score unit
// Opcodes, register indexes, state codes and the accumulator control bundle.
// ----------------------------------------------------------------------------
package rxas_pkg;

  localparam int ACC_W  = 128;  // exact sum needs at most 116 bits
  localparam int DIFF_W = 33;
  localparam int COEF_W = 32;

  localparam logic [1:0] OP_COEF  = 2'd0;
  localparam logic [1:0] OP_MEAN  = 2'd1;
  localparam logic [1:0] OP_PIXEL = 2'd2;

  localparam logic [1:0] CFG_BAND_COUNT = 2'd0;
  localparam logic [1:0] CFG_COEF_SHIFT = 2'd1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIFF  = 5'b00010,
    S_RUN   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctl_t;

endpackage

/* sv/rxas_mul_cell.sv */
// ----------------------------------------------------------------------------
// rxas_mul_cell: one registered signed multiply cell
// Takes two signed operands and hands the full product to the next cell.
// ----------------------------------------------------------------------------
module rxas_mul_cell #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [AW-1:0]       a,
  input  logic signed [BW-1:0]       b,
  output logic signed [AW+BW-1:0]    p
);

  logic signed [AW+BW-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

  assign p = p_r;

endmodule

/* sv/rxas_acc.sv */
// ----------------------------------------------------------------------------
// rxas_acc: saturating 128-bit score accumulator and result formatter
// Adds one term per add strobe and forms the shifted, clamped score.
// ----------------------------------------------------------------------------
module rxas_acc (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rxas_pkg::acc_ctl_t                  ctl,
  input  logic signed [rxas_pkg::ACC_W-1:0]   term,
  input  logic [5:0]                          coef_shift,
  output logic [63:0]                         score,
  output logic                                saturated,
  output logic                                negative_clamped
);

  logic signed [rxas_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic                              ovf_r, ovf_nxt;
  logic signed [rxas_pkg::ACC_W-1:0] sum;
  logic [rxas_pkg::ACC_W-1:0]        shifted;

  assign sum = acc_r + term;

  always_comb begin
    acc_nxt = acc_r;
    ovf_nxt = ovf_r;
    if (ctl.clear) begin
      acc_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (ctl.add) begin
      acc_nxt = sum;
      // clamp on signed overflow
      if ((acc_r[rxas_pkg::ACC_W-1] == term[rxas_pkg::ACC_W-1]) &&
          (sum[rxas_pkg::ACC_W-1] != acc_r[rxas_pkg::ACC_W-1])) begin
        ovf_nxt = 1'b1;
        acc_nxt = acc_r[rxas_pkg::ACC_W-1] ? {1'b1, {(rxas_pkg::ACC_W-1){1'b0}}}
                                           : {1'b0, {(rxas_pkg::ACC_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign shifted = unsigned'(acc_r) >> coef_shift;

  always_comb begin
    score            = '0;
    saturated        = 1'b0;
    negative_clamped = 1'b0;
    if (acc_r[rxas_pkg::ACC_W-1]) begin
      negative_clamped = 1'b1;
    end else if (ovf_r || (shifted[rxas_pkg::ACC_W-1:64] != '0)) begin
      score     = '1;
      saturated = 1'b1;
    end else begin
      score = shifted[63:0];
    end
  end

endmodule

/* sv/rx_anomaly_score_unit.sv */
// ----------------------------------------------------------------------------
// rx_anomaly_score_unit: global RX anomaly detector
// Loads an inverse covariance table and a mean vector, then scores pixels
// band by band as the Mahalanobis distance squared.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid/in_ready, op, row, col, value    | request in
//  out     | out_valid/out_ready, score, flags         | result out
//  cfg     | cfg_we, cfg_index, cfg_data               | register write
//
// A load request completes without leaving the idle state. A pixel sample
// for band k passes a mean read, a difference step, k+1 issues into the
// multiply cell chain (one per earlier band plus the diagonal) and a drain
// until the chain is empty. After the last band a finish state forms the
// result; it waits in an output register while the next request is taken.
// Reset is synchronous, active low; it clears control state and the
// accumulator. Table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module rx_anomaly_score_unit #(
  parameter int MAX_BANDS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [7:0]         in_row_index,
  input  logic [7:0]         in_col_index,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_score,
  output logic               out_saturated,
  output logic               out_negative_clamped,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);

  localparam int AW  = $clog2(MAX_BANDS);
  localparam int IW  = ((AW > 8) ? AW : 8) + 1;
  localparam int CD  = 1 << (2 * AW);
  localparam int LIM = (MAX_BANDS < 256) ? MAX_BANDS : 256;

  // configuration
  logic [8:0] band_count_r;
  logic [5:0] coef_shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_count_r <= 9'd1;
      coef_shift_r <= 6'd30;
    end else if (cfg_we) begin
      case (cfg_index)
        rxas_pkg::CFG_BAND_COUNT: band_count_r <= cfg_data;
        rxas_pkg::CFG_COEF_SHIFT: coef_shift_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  logic [8:0] n_eff;
  always_comb begin
    n_eff = band_count_r;
    if (band_count_r == 9'd0) n_eff = 9'd1;
    if (band_count_r > 9'(LIM)) n_eff = 9'(LIM);
  end

  // request decode
  logic           accept;
  logic [IW-1:0]  rowx, colx;
  logic           row_ok, col_ok;

  assign accept = in_valid && in_ready;
  assign rowx   = IW'(in_row_index);
  assign colx   = IW'(in_col_index);
  assign row_ok = rowx < IW'(MAX_BANDS);
  assign col_ok = colx < IW'(MAX_BANDS);

  // sequencer
  rxas_pkg::state_t state_r, state_nxt;
  logic [7:0]          k_r, j_r;
  logic                last_r;
  logic signed [31:0]  val_r;
  logic signed [32:0]  dk_r;
  logic [3:0]          vld_r;   // valid bits of the cell chain stages
  logic                diag0_r, issue;
  logic                out_valid_r;
  logic [63:0]         out_score_r;
  logic                out_sat_r, out_neg_r;
  logic [IW-1:0]       kx, jx;

  assign kx = IW'(k_r);
  assign jx = IW'(j_r);
  assign in_ready = (state_r == rxas_pkg::S_IDLE);
  assign issue    = (state_r == rxas_pkg::S_RUN);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rxas_pkg::S_IDLE: begin
        if (accept && in_op == rxas_pkg::OP_PIXEL && {1'b0, in_row_index} < n_eff)
          state_nxt = rxas_pkg::S_DIFF;
      end
      rxas_pkg::S_DIFF:  state_nxt = rxas_pkg::S_RUN;
      rxas_pkg::S_RUN:   if (j_r == k_r) state_nxt = rxas_pkg::S_DRAIN;
      rxas_pkg::S_DRAIN: begin
        if (vld_r == '0) state_nxt = last_r ? rxas_pkg::S_FIN : rxas_pkg::S_IDLE;
      end
      rxas_pkg::S_FIN: begin
        if (!out_valid_r || out_ready) state_nxt = rxas_pkg::S_IDLE;
      end
      default: state_nxt = rxas_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rxas_pkg::S_IDLE;
      vld_r   <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= {vld_r[2:0], issue};
      if (state_r == rxas_pkg::S_DIFF) j_r <= '0;
      else if (issue) j_r <= j_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      k_r    <= in_row_index;
      val_r  <= in_value;
      last_r <= ({1'b0, in_row_index} == n_eff - 9'd1);
    end
  end

  // memories
  logic signed [31:0] coef_mem [0:CD-1];
  logic signed [31:0] mean_mem [0:MAX_BANDS-1];
  logic signed [32:0] diff_mem [0:MAX_BANDS-1];
  logic signed [31:0] mean_q, coef_a_q, coef_b_q;
  logic signed [32:0] diff_q;

  always_ff @(posedge clk) begin
    if (accept && in_op == rxas_pkg::OP_COEF && row_ok && col_ok)
      coef_mem[{rowx[AW-1:0], colx[AW-1:0]}] <= in_value;
    if (accept && in_op == rxas_pkg::OP_MEAN && row_ok)
      mean_mem[rowx[AW-1:0]] <= in_value;
    mean_q   <= mean_mem[rowx[AW-1:0]];
    // hold the row's own entry and its transposed twin
    coef_a_q <= coef_mem[{kx[AW-1:0], jx[AW-1:0]}];
    coef_b_q <= coef_mem[{jx[AW-1:0], kx[AW-1:0]}];
    diff_q   <= diff_mem[jx[AW-1:0]];
    diag0_r  <= (j_r == k_r);
  end

  logic signed [32:0] dk;
  assign dk = {val_r[31], val_r} - {mean_q[31], mean_q};

  always_ff @(posedge clk) begin
    if (state_r == rxas_pkg::S_DIFF) begin
      dk_r <= dk;
      diff_mem[kx[AW-1:0]] <= dk;
    end
  end

  // cell chain: d_k*d_j, then the product split times the merged coefficient
  logic signed [32:0]  c1_r;
  logic signed [65:0]  p_dd;
  logic signed [66:0]  m_lo;
  logic signed [65:0]  m_hi;
  logic signed [rxas_pkg::ACC_W-1:0] term_r;

  rxas_mul_cell #(.AW(33), .BW(33)) u_cell_dd (
    .clk(clk), .en(vld_r[0]), .a(dk_r), .b(diff_q), .p(p_dd)
  );

  always_ff @(posedge clk) begin
    if (vld_r[0])
      c1_r <= diag0_r ? {coef_a_q[31], coef_a_q}
                      : {coef_a_q[31], coef_a_q} + {coef_b_q[31], coef_b_q};
  end

  rxas_mul_cell #(.AW(34), .BW(33)) u_cell_lo (
    .clk(clk), .en(vld_r[1]), .a({1'b0, p_dd[32:0]}), .b(c1_r), .p(m_lo)
  );

  rxas_mul_cell #(.AW(33), .BW(33)) u_cell_hi (
    .clk(clk), .en(vld_r[1]), .a(p_dd[65:33]), .b(c1_r), .p(m_hi)
  );

  always_ff @(posedge clk) begin
    if (vld_r[2])
      term_r <= {{29{m_hi[65]}}, m_hi, 33'd0} + {{61{m_lo[66]}}, m_lo};
  end

  // accumulator
  rxas_pkg::acc_ctl_t acc_ctl;
  logic [63:0]        fin_score;
  logic               fin_sat, fin_neg, fin_load;

  assign fin_load      = (state_r == rxas_pkg::S_FIN) && (!out_valid_r || out_ready);
  // clear at the first band of a pixel and when a result moves to the output register
  assign acc_ctl.clear = (accept && in_op == rxas_pkg::OP_PIXEL &&
                          in_row_index == 8'd0 && {1'b0, in_row_index} < n_eff) || fin_load;
  assign acc_ctl.add   = vld_r[3];

  rxas_acc u_acc (
    .clk(clk), .rst_n(rst_n), .ctl(acc_ctl), .term(term_r), .coef_shift(coef_shift_r),
    .score(fin_score), .saturated(fin_sat), .negative_clamped(fin_neg)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_score_r <= fin_score;
      out_sat_r   <= fin_sat;
      out_neg_r   <= fin_neg;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_score            = out_score_r;
  assign out_saturated        = out_sat_r;
  assign out_negative_clamped = out_neg_r;

endmodule

/* sv/rxas_checker.sv */
// ----------------------------------------------------------------------------
// rxas_checker: port-level checks of the RX anomaly score unit
// Watches the result channel for stable holds and consistent flags.
// ----------------------------------------------------------------------------
module rxas_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_score,
  input logic        out_saturated,
  input logic        out_negative_clamped
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_score))
    else $error("result changed while stalled");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_saturated && out_negative_clamped))
    else $error("both flags set");

  a_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_negative_clamped |-> out_score == 64'd0)
    else $error("negative clamp with nonzero score");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_score == '1)
    else $error("saturation without full-scale score");

endmodule

bind rx_anomaly_score_unit rxas_checker u_rxas_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_score(out_score), .out_saturated(out_saturated),
  .out_negative_clamped(out_negative_clamped)
);
